// File: hw/rtl/tht_pkg.sv
`timescale 1ns / 1ps
// Shared constants, arctangent table and pipeline payload types for the target heading block.
package tht_pkg;

  localparam int COORD_W = 16;
  localparam int HEAD_W  = 15;
  localparam int FRAC_W  = 8;
  localparam int STAGES  = 16;

  // x/y datapath: coordinate difference, fraction bits, CORDIC growth headroom
  localparam int XW = COORD_W + 1 + FRAC_W + 3;
  localparam int ZW = 34;
  localparam int KW = 30;
  localparam int PW = XW - 1;
  localparam int HI_W = PW - 16;
  localparam int QW = HI_W + KW + 1;
  localparam int RND_SH = 14 + FRAC_W;

  localparam int DIST_W = 17;
  localparam int IN_TDATA_W  = 80;
  localparam int OUT_TDATA_W = 40;

  localparam logic [KW-1:0]        INV_GAIN = 30'd652032874;
  localparam logic signed [ZW-1:0] PI_Z     = 34'sd3373259426;
  localparam logic signed [HEAD_W-1:0] PI_Q12 = 15'sd12868;
  localparam logic [DIST_W-1:0]    DIST_MAX = 17'd131071;

  // atan(2^-i) in radians * 2^30, truncated
  localparam logic signed [ZW-1:0] ATAN_TAB [32] = '{
    34'sd843314856, 34'sd497837829, 34'sd263043836, 34'sd133525158,
    34'sd67021686,  34'sd33543515,  34'sd16775850,  34'sd8388437,
    34'sd4194282,   34'sd2097149,   34'sd1048575,   34'sd524287,
    34'sd262143,    34'sd131071,    34'sd65535,     34'sd32767,
    34'sd16383,     34'sd8191,      34'sd4095,      34'sd2047,
    34'sd1023,      34'sd511,       34'sd255,       34'sd127,
    34'sd63,        34'sd31,        34'sd15,        34'sd8,
    34'sd4,         34'sd2,         34'sd1,         34'sd0
  };

  typedef struct packed {
    logic signed [XW-1:0]     x;
    logic signed [XW-1:0]     y;
    logic signed [ZW-1:0]     z;
    logic                     zero;
    logic signed [HEAD_W-1:0] heading;
  } cordic_t;

  typedef struct packed {
    logic [HI_W+KW-1:0]       prod_hi;
    logic [16+KW-1:0]         prod_lo;
    logic signed [HEAD_W-1:0] bearing;
    logic signed [HEAD_W-1:0] heading;
    logic                     zero;
  } post_t;

endpackage

// File: hw/rtl/target_heading_and_turn.sv
`timescale 1ns / 1ps
// Pipeline: a request passes 19 register stages (1 prep, 16 CORDIC, 2 post) before it
//   reaches out_tvalid and out_tdata.
// Throughput: one request per cycle; every stage has its own valid bit and a ready chain,
//   so bubbles are squeezed out and in_tready only drops when all 19 stages hold data
//   and out_tready is low.
// Reset: synchronous, active low rst_n clears every valid bit; payload is not reset.
// Results: distance (saturating), bearing atan2(dy,dx) in Q3.12, turn-left flag.
module target_heading_and_turn (
  input  logic                               clk,
  input  logic                               rst_n,
  // request: [15:0] robot_x, [31:16] robot_y, [46:32] robot_heading,
  //          [62:47] target_x, [78:63] target_y, [79] zero pad
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [tht_pkg::IN_TDATA_W-1:0]     in_tdata,
  // result: [16:0] distance, [31:17] bearing, [32] turn_left, [39:33] zero pad
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [tht_pkg::OUT_TDATA_W-1:0]    out_tdata
);

  localparam int CW = tht_pkg::COORD_W;
  localparam int HW = tht_pkg::HEAD_W;
  localparam int DW = tht_pkg::DIST_W;

  // field positions inside in_tdata
  localparam int RY_LO = CW;
  localparam int HD_LO = 2 * CW;
  localparam int TX_LO = 2 * CW + HW;
  localparam int TY_LO = 3 * CW + HW;

  logic             prep_valid, prep_ready;
  tht_pkg::cordic_t prep_data;
  logic             cor_valid, cor_ready;
  tht_pkg::cordic_t cor_data;

  logic [DW-1:0]        distance;
  logic signed [HW-1:0] bearing;
  logic                 turn_left;

  // differences and half-plane folding into the first register
  tht_prep u_prep (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_tvalid),
    .in_ready      (in_tready),
    .robot_x       (in_tdata[RY_LO-1:0]),
    .robot_y       (in_tdata[HD_LO-1:RY_LO]),
    .robot_heading (in_tdata[TX_LO-1:HD_LO]),
    .target_x      (in_tdata[TY_LO-1:TX_LO]),
    .target_y      (in_tdata[TY_LO+CW-1:TY_LO]),
    .out_valid     (prep_valid),
    .out_ready     (prep_ready),
    .out_data      (prep_data)
  );

  // one micro-rotation per stage, angle accumulated alongside
  tht_cordic u_cordic (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (prep_valid),
    .in_ready  (prep_ready),
    .in_data   (prep_data),
    .out_valid (cor_valid),
    .out_ready (cor_ready),
    .out_data  (cor_data)
  );

  // 1/gain scaling in two partial products, then rounding and the turn test
  tht_post u_post (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (cor_valid),
    .in_ready  (cor_ready),
    .in_data   (cor_data),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .distance  (distance),
    .bearing   (bearing),
    .turn_left (turn_left)
  );

  assign out_tdata = {{(tht_pkg::OUT_TDATA_W - DW - HW - 1){1'b0}}, turn_left, bearing, distance};

endmodule

// File: hw/rtl/tht_prep.sv
`timescale 1ns / 1ps
// Input stage: coordinate differences and half-plane pre-rotation.
module tht_prep (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [tht_pkg::COORD_W-1:0] robot_x,
  input  logic [tht_pkg::COORD_W-1:0] robot_y,
  input  logic [tht_pkg::HEAD_W-1:0]  robot_heading,
  input  logic [tht_pkg::COORD_W-1:0] target_x,
  input  logic [tht_pkg::COORD_W-1:0] target_y,
  output logic                        out_valid,
  input  logic                        out_ready,
  output tht_pkg::cordic_t            out_data
);

  localparam int CW = tht_pkg::COORD_W;
  localparam int XW = tht_pkg::XW;
  localparam int PADW = XW - CW - 1 - tht_pkg::FRAC_W;

  logic                 valid_r;
  tht_pkg::cordic_t     data_r, data_nxt;
  logic signed [CW:0]   dx, dy;
  logic signed [XW-1:0] x0, y0;

  assign dx = $signed({target_x[CW-1], target_x}) - $signed({robot_x[CW-1], robot_x});
  assign dy = $signed({target_y[CW-1], target_y}) - $signed({robot_y[CW-1], robot_y});
  assign x0 = {{PADW{dx[CW]}}, dx, {tht_pkg::FRAC_W{1'b0}}};
  assign y0 = {{PADW{dy[CW]}}, dy, {tht_pkg::FRAC_W{1'b0}}};

  always_comb begin
    data_nxt.heading = robot_heading;
    data_nxt.zero    = (dx == '0) && (dy == '0);
    if (dx[CW]) begin
      // left half plane: negate and start from +/- pi
      data_nxt.x = -x0;
      data_nxt.y = -y0;
      data_nxt.z = dy[CW] ? -tht_pkg::PI_Z : tht_pkg::PI_Z;
    end else begin
      data_nxt.x = x0;
      data_nxt.y = y0;
      data_nxt.z = '0;
    end
  end

  assign in_ready  = !valid_r || out_ready;
  assign out_valid = valid_r;
  assign out_data  = data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      data_r <= data_nxt;
    end
  end

endmodule

// File: hw/rtl/tht_cordic.sv
`timescale 1ns / 1ps
// Vectoring CORDIC pipeline, one micro-rotation per register stage.
module tht_cordic (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  tht_pkg::cordic_t in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output tht_pkg::cordic_t out_data
);

  localparam int N  = tht_pkg::STAGES;
  localparam int XW = tht_pkg::XW;
  localparam int ZW = tht_pkg::ZW;

  logic [N-1:0]     valid_r;
  logic [N:0]       rdy;
  tht_pkg::cordic_t stg_r   [N];
  tht_pkg::cordic_t stg_nxt [N];

  assign rdy[N]    = out_ready;
  assign in_ready  = rdy[0];
  assign out_valid = valid_r[N-1];
  assign out_data  = stg_r[N-1];

  for (genvar i = 0; i < N; i++) begin : g_stage
    tht_pkg::cordic_t     src;
    logic                 src_v;
    logic signed [XW-1:0] xi, yi, xs, ys;
    logic signed [ZW-1:0] zi;

    if (i == 0) begin : g_first
      assign src   = in_data;
      assign src_v = in_valid;
    end else begin : g_next
      assign src   = stg_r[i-1];
      assign src_v = valid_r[i-1];
    end

    assign rdy[i] = !valid_r[i] || rdy[i+1];
    assign xi = src.x;
    assign yi = src.y;
    assign zi = src.z;
    assign xs = xi >>> i;
    assign ys = yi >>> i;

    always_comb begin
      stg_nxt[i].zero    = src.zero;
      stg_nxt[i].heading = src.heading;
      if (!yi[XW-1]) begin
        stg_nxt[i].x = xi + ys;
        stg_nxt[i].y = yi - xs;
        stg_nxt[i].z = zi + tht_pkg::ATAN_TAB[i];
      end else begin
        stg_nxt[i].x = xi - ys;
        stg_nxt[i].y = yi + xs;
        stg_nxt[i].z = zi - tht_pkg::ATAN_TAB[i];
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        valid_r[i] <= 1'b0;
      end else if (rdy[i]) begin
        valid_r[i] <= src_v;
      end
    end

    always_ff @(posedge clk) begin
      if (rdy[i] && src_v) begin
        stg_r[i] <= stg_nxt[i];
      end
    end
  end

endmodule

// File: hw/rtl/tht_post.sv
`timescale 1ns / 1ps
// Gain correction, rounding, clamping and turn decision; second stage is the output register.
module tht_post (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  tht_pkg::cordic_t                    in_data,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [tht_pkg::DIST_W-1:0]          distance,
  output logic signed [tht_pkg::HEAD_W-1:0]   bearing,
  output logic                                turn_left
);

  localparam int XW = tht_pkg::XW;
  localparam int ZW = tht_pkg::ZW;
  localparam int HW = tht_pkg::HEAD_W;
  localparam int PW = tht_pkg::PW;
  localparam int HI_W = tht_pkg::HI_W;
  localparam int KW = tht_pkg::KW;
  localparam int QW = tht_pkg::QW;
  localparam int SH = tht_pkg::RND_SH;
  localparam int BW = ZW + 1 - 18;

  // stage 1: partial products and bearing
  logic                  p1_valid_r;
  tht_pkg::post_t        p1_r, p1_nxt;
  logic                  p1_rdy;
  logic [PW-1:0]         mag;
  logic signed [ZW:0]    z_rnd;
  logic signed [BW-1:0]  b_wide;
  logic signed [BW-1:0]  pi_wide;

  assign mag     = in_data.x[XW-1] ? '0 : in_data.x[PW-1:0];
  assign z_rnd   = $signed({in_data.z[ZW-1], in_data.z}) + $signed((ZW+1)'(1 << 17));
  assign b_wide  = z_rnd[ZW:18];
  assign pi_wide = BW'(tht_pkg::PI_Q12);

  always_comb begin
    p1_nxt.prod_hi = (HI_W+KW)'(mag[PW-1:16]) * (HI_W+KW)'(tht_pkg::INV_GAIN);
    p1_nxt.prod_lo = (16+KW)'(mag[15:0]) * (16+KW)'(tht_pkg::INV_GAIN);
    p1_nxt.heading = in_data.heading;
    p1_nxt.zero    = in_data.zero;
    if (in_data.zero) begin
      p1_nxt.bearing = '0;
    end else if (b_wide > pi_wide) begin
      p1_nxt.bearing = tht_pkg::PI_Q12;
    end else if (b_wide < -pi_wide) begin
      p1_nxt.bearing = -tht_pkg::PI_Q12;
    end else begin
      p1_nxt.bearing = b_wide[HW-1:0];
    end
  end

  // stage 2: sum, round, saturate, turn test
  logic                       o_valid_r;
  logic [tht_pkg::DIST_W-1:0] dist_r, dist_nxt;
  logic signed [HW-1:0]       bear_r;
  logic                       left_r, left_nxt;
  logic [QW-1:0]              q, q_rnd;
  logic [QW-SH-1:0]           d_wide;
  logic signed [HW+1:0]       h_e, b_e, pi_e;

  assign q      = QW'(p1_r.prod_hi) + QW'(p1_r.prod_lo[16+KW-1:16]);
  assign q_rnd  = q + QW'(1 << (SH - 1));
  assign d_wide = q_rnd[QW-1:SH];
  assign h_e    = (HW+2)'(p1_r.heading);
  assign b_e    = (HW+2)'(p1_r.bearing);
  assign pi_e   = (HW+2)'(tht_pkg::PI_Q12);

  always_comb begin
    if (p1_r.zero) begin
      dist_nxt = '0;
    end else if (d_wide > (QW-SH)'(tht_pkg::DIST_MAX)) begin
      dist_nxt = tht_pkg::DIST_MAX;
    end else begin
      dist_nxt = d_wide[tht_pkg::DIST_W-1:0];
    end
    if ((!h_e[HW+1] && !b_e[HW+1]) || (h_e <= 0 && b_e <= 0)) begin
      left_nxt = (b_e >= h_e);
    end else if (h_e > 0) begin
      left_nxt = !(b_e >= h_e - pi_e);
    end else begin
      left_nxt = (b_e <= h_e + pi_e);
    end
  end

  assign in_ready  = !p1_valid_r || p1_rdy;
  assign p1_rdy    = !o_valid_r || out_ready;
  assign out_valid = o_valid_r;
  assign distance  = dist_r;
  assign bearing   = bear_r;
  assign turn_left = left_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p1_valid_r <= 1'b0;
      o_valid_r  <= 1'b0;
    end else begin
      if (in_ready) begin
        p1_valid_r <= in_valid;
      end
      if (p1_rdy) begin
        o_valid_r <= p1_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      p1_r <= p1_nxt;
    end
    if (p1_rdy && p1_valid_r) begin
      dist_r <= dist_nxt;
      bear_r <= p1_r.bearing;
      left_r <= left_nxt;
    end
  end

endmodule

// File: tb/tb_top.sv
`timescale 1ns / 1ps
// Self-checking bench for target_heading_and_turn: random and corner requests, scored result by result.
module tb_top;

  // Bench timing. STALL_LIMIT is in cycles with no handshake on either channel.
  // It covers the receiver hold-off, the 19-stage latency and long random idle runs.
  localparam int HALF_PERIOD = 5;
  localparam int RESET_CYCLES = 11;
  localparam int STALL_LIMIT = 4000;
  localparam int DRAIN_CYCLES = 25;
  localparam int HOLD_OFF_CYCLES = 120;
  localparam int ITEMS_PER_PHASE = 200;

  // One request, packed as it sits on in_tdata (robot_x in the low bits).
  typedef struct packed {
    logic signed [15:0] target_y;
    logic signed [15:0] target_x;
    logic signed [14:0] robot_heading;
    logic signed [15:0] robot_y;
    logic signed [15:0] robot_x;
  } request_t;

  // One result, packed as it sits on out_tdata below the pad.
  typedef struct packed {
    logic               turn_left;
    logic signed [14:0] bearing;
    logic [16:0]        distance;
  } guidance_t;

  // Keeps the expected results of accepted requests, oldest first, and scores each result.
  class guidance_scoreboard;
    localparam longint PI_Q30 = 64'sd3373259426;
    localparam longint PI_Q12 = 64'sd12868;
    localparam longint unsigned INV_GAIN_Q30 = 64'd652032874;
    localparam longint unsigned DIST_LIMIT = 64'd131071;

    guidance_t awaited[$];
    int failures;

    function new();
      failures = 0;
    endfunction

    // Vectoring CORDIC on the offset, gain correction, rounding, then the turn decision.
    static function guidance_t compute_guidance(request_t r);
      longint atan_q30 [16];
      longint dx, dy, x, y, z, xs, ys, b, h;
      longint unsigned p, q;
      guidance_t g;
      atan_q30 = '{64'sd843314856, 64'sd497837829, 64'sd263043836, 64'sd133525158,
                   64'sd67021686,  64'sd33543515,  64'sd16775850,  64'sd8388437,
                   64'sd4194282,   64'sd2097149,   64'sd1048575,   64'sd524287,
                   64'sd262143,    64'sd131071,    64'sd65535,     64'sd32767};
      dx = longint'(r.target_x) - longint'(r.robot_x);
      dy = longint'(r.target_y) - longint'(r.robot_y);
      h = longint'(r.robot_heading);
      z = 0;
      b = 0;
      g.distance = '0;
      if (dx != 0 || dy != 0) begin
        x = dx * 256;
        y = dy * 256;
        // left half plane: fold onto the right and start from +/-pi
        if (dx < 0) begin
          z = (dy >= 0) ? PI_Q30 : -PI_Q30;
          x = -x;
          y = -y;
        end
        for (int i = 0; i < 16; i++) begin
          xs = x >>> i;
          ys = y >>> i;
          if (y >= 0) begin
            x = x + ys;
            y = y - xs;
            z = z + atan_q30[i];
          end else begin
            x = x - ys;
            y = y + xs;
            z = z - atan_q30[i];
          end
        end
        p = (x < 0) ? 64'd0 : longint'(x);
        q = (p >> 16) * INV_GAIN_Q30 + (((p & 64'hFFFF) * INV_GAIN_Q30) >> 16);
        q = (q + (64'd1 << 21)) >> 22;
        g.distance = (q > DIST_LIMIT) ? 17'(DIST_LIMIT) : 17'(q);
        b = (z + (64'sd1 << 17)) >>> 18;
        if (b > PI_Q12) b = PI_Q12;
        if (b < -PI_Q12) b = -PI_Q12;
      end
      g.bearing = 15'(b);
      // heading compared as given, no wrapping
      if ((h >= 0 && b >= 0) || (h <= 0 && b <= 0)) g.turn_left = (b >= h);
      else if (h > 0) g.turn_left = !(b >= h - PI_Q12);
      else g.turn_left = (b <= h + PI_Q12);
      return g;
    endfunction

    function void note_request(request_t r);
      awaited.push_back(compute_guidance(r));
    endfunction

    function void check_result(logic [32:0] raw);
      guidance_t got, want;
      got = raw;
      if (awaited.size() == 0) begin
        $error("unexpected result: distance %0d bearing %0d turn_left %0d",
               got.distance, got.bearing, got.turn_left);
        failures++;
        return;
      end
      want = awaited.pop_front();
      if (got.distance !== want.distance) begin
        $error("distance: expected %0d, actual %0d", want.distance, got.distance);
        failures++;
      end
      if (got.bearing !== want.bearing) begin
        $error("bearing: expected %0d, actual %0d", want.bearing, got.bearing);
        failures++;
      end
      if (got.turn_left !== want.turn_left) begin
        $error("turn_left: expected %0d, actual %0d", want.turn_left, got.turn_left);
        failures++;
      end
    endfunction
  endclass

  logic                            clk = 1'b0;
  logic                            rst_n;
  logic                            in_tvalid;
  logic                            in_tready;
  logic [tht_pkg::IN_TDATA_W-1:0]  in_tdata;
  logic                            out_tvalid;
  logic                            out_tready;
  logic [tht_pkg::OUT_TDATA_W-1:0] out_tdata;

  // Idle odds in percent, set per phase by the stimulus process.
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  // Raised once by the stimulus; the receiver then holds off on its own count.
  bit squeeze_pending = 1'b0;

  guidance_scoreboard sb = new();

  always #HALF_PERIOD clk = ~clk;

  target_heading_and_turn u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  function automatic request_t mk_request(int rx, int ry, int h, int tx, int ty);
    request_t r;
    r.robot_x = 16'(rx);
    r.robot_y = 16'(ry);
    r.robot_heading = 15'(h);
    r.target_x = 16'(tx);
    r.target_y = 16'(ty);
    return r;
  endfunction

  // Full-range requests, plus near, on-axis, coincident and corner-heavy ones.
  function automatic request_t make_random_request();
    request_t r;
    logic [15:0] corner [4];
    corner = '{16'h8000, 16'h7FFF, 16'h0000, 16'hFFFF};
    r.robot_x = 16'($urandom);
    r.robot_y = 16'($urandom);
    r.target_x = 16'($urandom);
    r.target_y = 16'($urandom);
    case ($urandom_range(9))
      0:       r.robot_heading = 15'($urandom);   // whole field, out of range too
      1:       r.robot_heading = 15'(12868);
      2:       r.robot_heading = 15'(-12868);
      3:       r.robot_heading = '0;
      default: r.robot_heading = 15'($urandom_range(25736) - 12868);
    endcase
    case ($urandom_range(9))
      4, 5: begin
        // target close by: exercises small vectors and fine bearings
        r.target_x = r.robot_x + 16'($urandom_range(512)) - 16'd256;
        r.target_y = r.robot_y + 16'($urandom_range(512)) - 16'd256;
      end
      6: begin
        if ($urandom_range(1) == 0) r.target_x = r.robot_x;
        else r.target_y = r.robot_y;
      end
      7: begin
        r.target_x = r.robot_x;
        r.target_y = r.robot_y;
      end
      8, 9: begin
        r.robot_x = corner[$urandom_range(3)];
        r.robot_y = corner[$urandom_range(3)];
        r.target_x = corner[$urandom_range(3)];
        r.target_y = corner[$urandom_range(3)];
      end
      default: ;
    endcase
    return r;
  endfunction

  // Offer one request from a falling edge, hold it until accepted, return on the next falling edge.
  task automatic send_request(request_t r);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {1'b0, r};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sb.note_request(r);
    @(negedge clk);
  endtask

  // Result side: random back-pressure, and one long hold-off to fill the pipe.
  initial begin : receiver
    out_tready <= 1'b0;
    forever begin
      @(negedge clk);
      if (squeeze_pending) begin
        squeeze_pending = 1'b0;
        out_tready <= 1'b0;
        repeat (HOLD_OFF_CYCLES - 1) @(negedge clk);
      end else begin
        out_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // Results are scored at the rising edge they are taken.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_result(out_tdata[32:0]);
  end

  // Ends the run, reported as failed, if neither channel moves within the bench's stall limit.
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet = 0;
      else quiet++;
    end
    $display("Simulation FAILED");
    $finish;
  end

  initial begin : stimulus
    request_t directed[$];
    rst_n <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata <= '0;

    // target on robot, with heading zero, positive and negative
    directed.push_back(mk_request(0, 0, 0, 0, 0));
    directed.push_back(mk_request(1234, -777, 5000, 1234, -777));
    directed.push_back(mk_request(-32768, 32767, -5000, -32768, 32767));
    // widest offsets along each axis
    directed.push_back(mk_request(-32768, 0, 0, 32767, 0));
    directed.push_back(mk_request(32767, 0, 0, -32768, 0));
    directed.push_back(mk_request(0, -32768, 0, 0, 32767));
    directed.push_back(mk_request(0, 32767, 0, 0, -32768));
    // widest diagonals, both quadrants of the far side too
    directed.push_back(mk_request(-32768, -32768, 0, 32767, 32767));
    directed.push_back(mk_request(32767, 32767, 0, -32768, -32768));
    directed.push_back(mk_request(32767, -32768, 0, -32768, 32767));
    directed.push_back(mk_request(-32768, 32767, 0, 32767, -32768));
    // left half plane above and below the axis
    directed.push_back(mk_request(0, 0, 1000, -1000, 500));
    directed.push_back(mk_request(0, 0, -1000, -1000, -500));
    // opposite signs of heading and bearing, either side of heading -/+ pi
    directed.push_back(mk_request(0, 0, 3000, 1000, -1000));
    directed.push_back(mk_request(0, 0, 12000, -1000, -1000));
    directed.push_back(mk_request(0, 0, -3000, 1000, 1000));
    directed.push_back(mk_request(0, 0, -12000, -1000, 1000));
    // heading beyond and at +/-pi, compared unwrapped
    directed.push_back(mk_request(0, 0, 16383, -100, -1));
    directed.push_back(mk_request(0, 0, -16384, -100, 1));
    directed.push_back(mk_request(0, 0, 12868, -500, 0));
    directed.push_back(mk_request(0, 0, -12868, -500, 0));
    // same-sign headings above the bearing, and unit vectors
    directed.push_back(mk_request(0, 0, 100, 1, 0));
    directed.push_back(mk_request(0, 0, -100, -1, -1));
    directed.push_back(mk_request(5, 5, 8000, 6, 6));

    repeat (RESET_CYCLES) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // phase 0: sender idles a little, receiver a lot
    send_idle_pct = 20;
    recv_idle_pct = 86;
    foreach (directed[i]) send_request(directed[i]);
    for (int n = 0; n < ITEMS_PER_PHASE; n++) send_request(make_random_request());

    // phase 1: roles swapped
    send_idle_pct = 86;
    recv_idle_pct = 20;
    for (int n = 0; n < ITEMS_PER_PHASE; n++) send_request(make_random_request());

    // phase 2: no idling; receiver opens with a long hold-off so the pipe backs up
    send_idle_pct = 0;
    recv_idle_pct = 0;
    squeeze_pending = 1'b1;
    for (int n = 0; n < ITEMS_PER_PHASE; n++) send_request(make_random_request());

    in_tvalid <= 1'b0;
    while (sb.awaited.size() != 0) @(posedge clk);
    // catch any stray result past the pipeline depth
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (sb.failures == 0 && sb.awaited.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
